/* rtl/kmr_pkg.sv */
// Package for the keystroke macro recorder: store sizing, action and error codes,
// and the packed beat types of the input and result channels.
// No dependencies.
package kmr_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;

    localparam logic [2:0] ACT_RECORD = 3'd0;
    localparam logic [2:0] ACT_STOP   = 3'd1;
    localparam logic [2:0] ACT_PLAY   = 3'd2;
    localparam logic [2:0] ACT_KEY    = 3'd3;
    localparam logic [2:0] ACT_STEP   = 3'd4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIGIT = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic [15:0] DIGIT_ZERO = 16'h0030;
    localparam logic [15:0] DIGIT_NINE = 16'h0039;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] key_code;
        logic [7:0]  modifiers;
    } in_item_t;

    typedef struct packed {
        logic        key_valid;
        logic [15:0] key_out;
        logic [7:0]  modifiers_out;
        logic        pass_key;
        logic        recording;
        logic        playing;
        logic [1:0]  error;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  modifiers;
        logic [15:0] key_code;
    } store_entry_t;

endpackage

/* rtl/keystroke_macro_recorder_top.sv */
// Top level of the keystroke macro recorder: input register, state update logic
// and result register around the key store.
// Depends on kmr_pkg and kmr_store.

// The block takes one beat per clock cycle while the result side is not stalled,
// and returns exactly one result beat for each accepted beat. Every
// beat is handled in a single pass between the input register and the result
// register; the key store is read every cycle at the next playback position, so
// the stored key for a playback step is already waiting in the store's read
// register when the step is handled. The store needs no clearing after reset:
// playback only reads entries below the stored count, all of which were written.
module keystroke_macro_recorder_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  kmr_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output kmr_pkg::out_item_t result
);

    kmr_pkg::in_item_t  item_reg;
    logic               item_valid_reg;
    kmr_pkg::out_item_t result_reg;
    kmr_pkg::out_item_t result_next;
    logic               result_valid_reg;

    logic [kmr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [kmr_pkg::COUNT_W-1:0] pos_reg, pos_next;
    logic [3:0]                  total_reg, total_next;
    logic [3:0]                  done_reg, done_next;
    logic                        awaiting_reg, awaiting_next;
    logic                        rec_reg, rec_next;
    logic                        play_reg, play_next;
    logic                        stored_reg, stored_next;

    logic                  advance;
    logic                  wr_en;
    kmr_pkg::store_entry_t wr_data;
    kmr_pkg::store_entry_t rd_data;
    logic [15:0]           digit_offset;

    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    assign wr_data.key_code  = item_reg.key_code;
    assign wr_data.modifiers = item_reg.modifiers;
    assign digit_offset      = item_reg.key_code - kmr_pkg::DIGIT_ZERO;

    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        done_next     = done_reg;
        awaiting_next = awaiting_reg;
        rec_next      = rec_reg;
        play_next     = play_reg;
        stored_next   = stored_reg;
        wr_en         = 1'b0;
        result_next   = '0;

        if (advance)
        begin
            case (item_reg.action)
                kmr_pkg::ACT_RECORD:
                begin
                    stored_next   = 1'b1;
                    rec_next      = 1'b1;
                    play_next     = 1'b0;
                    pos_next      = '0;
                    count_next    = '0;
                    awaiting_next = 1'b1;
                    total_next    = 4'd1;
                end
                kmr_pkg::ACT_STOP:
                begin
                    rec_next = 1'b0;
                end
                kmr_pkg::ACT_PLAY:
                begin
                    if (stored_reg)
                    begin
                        pos_next  = '0;
                        done_next = '0;
                        rec_next  = 1'b0;
                        play_next = 1'b1;
                    end
                end
                kmr_pkg::ACT_KEY:
                begin
                    result_next.pass_key = 1'b1;
                    if (rec_reg)
                    begin
                        if (awaiting_reg)
                        begin
                            result_next.pass_key = 1'b0;
                            if ((item_reg.key_code >= kmr_pkg::DIGIT_ZERO) &&
                                (item_reg.key_code <= kmr_pkg::DIGIT_NINE))
                            begin
                                total_next    = digit_offset[3:0];
                                awaiting_next = 1'b0;
                            end
                            else
                            begin
                                rec_next          = 1'b0;
                                result_next.error = kmr_pkg::ERR_DIGIT;
                            end
                        end
                        else if (count_reg < kmr_pkg::COUNT_W'(kmr_pkg::STORE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            rec_next          = 1'b0;
                            result_next.error = kmr_pkg::ERR_FULL;
                        end
                    end
                end
                kmr_pkg::ACT_STEP:
                begin
                    if (play_reg)
                    begin
                        if (done_reg < total_reg)
                        begin
                            if (pos_reg < count_reg)
                            begin
                                result_next.key_valid     = 1'b1;
                                result_next.key_out       = rd_data.key_code;
                                result_next.modifiers_out = rd_data.modifiers;
                                pos_next                  = pos_reg + 1'b1;
                            end
                            else
                            begin
                                pos_next  = '0;
                                done_next = done_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            done_next = 4'd1;
                            play_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            result_next.recording = rec_next;
            result_next.playing   = play_next;
        end
    end

    kmr_store u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[kmr_pkg::ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (pos_next[kmr_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
            pos_reg          <= '0;
            total_reg        <= 4'd1;
            done_reg         <= '0;
            awaiting_reg     <= 1'b0;
            rec_reg          <= 1'b0;
            play_reg         <= 1'b0;
            stored_reg       <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            total_reg    <= total_next;
            done_reg     <= done_next;
            awaiting_reg <= awaiting_next;
            rec_reg      <= rec_next;
            play_reg     <= play_next;
            stored_reg   <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/kmr_store.sv */
// Key store of the macro recorder: one write port and one registered read port,
// with a write in the same cycle to the read address forwarded to the read data.
// Depends on kmr_pkg.
module kmr_store
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [kmr_pkg::ADDR_W-1:0]  wr_addr,
    input  kmr_pkg::store_entry_t       wr_data,
    input  logic [kmr_pkg::ADDR_W-1:0]  rd_addr,
    output kmr_pkg::store_entry_t       rd_data
);

    kmr_pkg::store_entry_t mem [kmr_pkg::STORE_DEPTH];
    kmr_pkg::store_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* verif/kmr_recorder_checker.sv */
`timescale 1ns / 100ps
// Checker for the keystroke macro recorder: predicts one result beat for every accepted
// input beat and compares the result channel against those predictions in order.
// Depends on kmr_pkg.
module kmr_recorder_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  kmr_pkg::in_item_t  item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  kmr_pkg::out_item_t result,
    output int                 fail_count,
    output int                 expected_left
);

    kmr_pkg::store_entry_t       recorded_keys [kmr_pkg::STORE_DEPTH];
    logic [kmr_pkg::COUNT_W-1:0] keys_held;
    logic [kmr_pkg::COUNT_W-1:0] replay_pos;
    logic [3:0]                  passes_wanted;
    logic [3:0]                  passes_done;
    logic                        awaiting_digit;
    logic                        rec_on;
    logic                        play_on;
    logic                        ever_recorded;
    kmr_pkg::out_item_t          pending_outcomes [$];
    int                          mismatches;

    task automatic predict_outcome(input kmr_pkg::in_item_t beat,
                                   output kmr_pkg::out_item_t res);
        logic [15:0]                digit_val;
        logic [kmr_pkg::ADDR_W-1:0] wr_idx;
        logic [kmr_pkg::ADDR_W-1:0] rd_idx;
        res = '0;
        digit_val = beat.key_code - kmr_pkg::DIGIT_ZERO;
        wr_idx    = keys_held[kmr_pkg::ADDR_W-1:0];
        rd_idx    = replay_pos[kmr_pkg::ADDR_W-1:0];
        case (beat.action)
            kmr_pkg::ACT_RECORD:
            begin
                ever_recorded  = 1'b1;
                rec_on         = 1'b1;
                play_on        = 1'b0;
                replay_pos     = '0;
                keys_held      = '0;
                awaiting_digit = 1'b1;
                passes_wanted  = 4'd1;
            end
            kmr_pkg::ACT_STOP:
            begin
                rec_on = 1'b0;
            end
            kmr_pkg::ACT_PLAY:
            begin
                if (ever_recorded)
                begin
                    replay_pos  = '0;
                    passes_done = '0;
                    rec_on      = 1'b0;
                    play_on     = 1'b1;
                end
            end
            kmr_pkg::ACT_KEY:
            begin
                res.pass_key = 1'b1;
                if (rec_on)
                begin
                    if (awaiting_digit)
                    begin
                        res.pass_key = 1'b0;
                        if (beat.key_code >= kmr_pkg::DIGIT_ZERO &&
                            beat.key_code <= kmr_pkg::DIGIT_NINE)
                        begin
                            passes_wanted  = digit_val[3:0];
                            awaiting_digit = 1'b0;
                        end
                        else
                        begin
                            rec_on    = 1'b0;
                            res.error = kmr_pkg::ERR_DIGIT;
                        end
                    end
                    else if (keys_held < kmr_pkg::STORE_DEPTH)
                    begin
                        recorded_keys[wr_idx].key_code  = beat.key_code;
                        recorded_keys[wr_idx].modifiers = beat.modifiers;
                        keys_held = keys_held + 1'b1;
                    end
                    else
                    begin
                        rec_on    = 1'b0;
                        res.error = kmr_pkg::ERR_FULL;
                    end
                end
            end
            kmr_pkg::ACT_STEP:
            begin
                if (play_on)
                begin
                    if (passes_done < passes_wanted)
                    begin
                        if (replay_pos < keys_held)
                        begin
                            res.key_valid     = 1'b1;
                            res.key_out       = recorded_keys[rd_idx].key_code;
                            res.modifiers_out = recorded_keys[rd_idx].modifiers;
                            replay_pos = replay_pos + 1'b1;
                        end
                        else
                        begin
                            replay_pos  = '0;
                            passes_done = passes_done + 4'd1;
                        end
                    end
                    else
                    begin
                        passes_done = 4'd1;
                        play_on     = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.recording = rec_on;
        res.playing   = play_on;
    endtask

    function automatic void note_field(string label, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    task automatic compare_outcome(input kmr_pkg::out_item_t got);
        kmr_pkg::out_item_t want;
        if (pending_outcomes.size() == 0)
        begin
            $display("%0t: result beat %h arrived with nothing expected", $time, got);
            mismatches++;
        end
        else
        begin
            want = pending_outcomes.pop_front();
            note_field("key_valid", want.key_valid, got.key_valid);
            note_field("key_out", want.key_out, got.key_out);
            note_field("modifiers_out", want.modifiers_out, got.modifiers_out);
            note_field("pass_key", want.pass_key, got.pass_key);
            note_field("recording", want.recording, got.recording);
            note_field("playing", want.playing, got.playing);
            note_field("error", want.error, got.error);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        kmr_pkg::out_item_t outcome;
        if (!rst_n)
        begin
            keys_held      = '0;
            replay_pos     = '0;
            passes_wanted  = 4'd1;
            passes_done    = '0;
            awaiting_digit = 1'b0;
            rec_on         = 1'b0;
            play_on        = 1'b0;
            ever_recorded  = 1'b0;
            mismatches     = 0;
            pending_outcomes.delete();
            fail_count    <= 0;
            expected_left <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                compare_outcome(result);
            end
            if (item_valid && item_ready)
            begin
                predict_outcome(item, outcome);
                pending_outcomes.push_back(outcome);
            end
            fail_count    <= mismatches;
            expected_left <= pending_outcomes.size();
        end
    end

endmodule

/* verif/keystroke_macro_recorder_top_test.sv */
`timescale 1ns / 100ps
// Testbench top for keystroke_macro_recorder_top: drives directed and random beats under
// changing idle rates and one long result stall, then gives the verdict.
// Depends on kmr_pkg, keystroke_macro_recorder_top and kmr_recorder_checker.
module keystroke_macro_recorder_top_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_BEATS = 170;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    kmr_pkg::in_item_t  item         = '0;
    logic               result_ready = 1'b0;
    logic               item_ready;
    logic               result_valid;
    kmr_pkg::out_item_t result;
    int                 fail_count;
    int                 expected_left;
    int                 tx_idle_pct   = 0;
    int                 rx_idle_pct   = 0;
    int                 hold_asked    = 0;
    int                 hold_granted  = 0;
    int                 hold_left     = 0;
    int                 cycle_count   = 0;
    int                 counted_beats = 0;

    always #1 clk = ~clk;

    keystroke_macro_recorder_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    kmr_recorder_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_asked != hold_granted)
        begin
            hold_granted = hold_asked;
            hold_left    = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(input logic [2:0] action, input logic [15:0] key_code,
                             input logic [7:0] modifiers);
        kmr_pkg::in_item_t beat;
        beat.action    = action;
        beat.key_code  = key_code;
        beat.modifiers = modifiers;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        if (action <= kmr_pkg::ACT_STEP)
        begin
            counted_beats++;
        end
    endtask

    task automatic send_noise();
        send_beat(3'($urandom_range(7)), 16'($urandom_range(65535)),
                  8'($urandom_range(255)));
    endtask

    task automatic run_session(input int key_total);
        int          passes;
        int          steps;
        int          shape;
        logic [15:0] bad_key;
        passes = $urandom_range(9);
        shape  = $urandom_range(99);
        send_beat(kmr_pkg::ACT_RECORD, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        if (shape < 12)
        begin
            bad_key = 16'($urandom_range(65535));
            if (bad_key >= kmr_pkg::DIGIT_ZERO && bad_key <= kmr_pkg::DIGIT_NINE)
            begin
                bad_key = bad_key + 16'h0100;
            end
            if (shape < 4)
            begin
                bad_key = kmr_pkg::DIGIT_ZERO - 16'd1;
            end
            else if (shape < 8)
            begin
                bad_key = kmr_pkg::DIGIT_NINE + 16'd1;
            end
            send_beat(kmr_pkg::ACT_KEY, bad_key, 8'($urandom_range(255)));
        end
        else
        begin
            send_beat(kmr_pkg::ACT_KEY, kmr_pkg::DIGIT_ZERO + 16'(passes),
                      8'($urandom_range(255)));
        end
        for (int i = 0; i < key_total; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_noise();
            end
            else
            begin
                send_beat(kmr_pkg::ACT_KEY, 16'($urandom_range(65535)),
                          8'($urandom_range(255)));
            end
        end
        if ($urandom_range(1) == 1)
        begin
            send_beat(kmr_pkg::ACT_STOP, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        end
        send_beat(kmr_pkg::ACT_PLAY, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        steps = (key_total + 1) * passes + 2;
        if ($urandom_range(99) < 15)
        begin
            steps = $urandom_range(steps);
        end
        for (int i = 0; i < steps; i++)
        begin
            if ($urandom_range(99) < 5)
            begin
                send_noise();
            end
            else
            begin
                send_beat(kmr_pkg::ACT_STEP, 16'($urandom_range(65535)),
                          8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_beat(kmr_pkg::ACT_STEP, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_PLAY, 16'hFFFF, 8'hFF);
        send_beat(kmr_pkg::ACT_KEY, 16'hFFFF, 8'hFF);
        send_beat(3'd5, 16'h1234, 8'h81);
        send_beat(3'd6, 16'h0031, 8'h42);
        send_beat(3'd7, 16'hFFFF, 8'hFF);
        send_beat(kmr_pkg::ACT_RECORD, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_KEY, 16'h0130, 8'h01);
        send_beat(kmr_pkg::ACT_RECORD, 16'hFFFF, 8'hFF);
        send_beat(kmr_pkg::ACT_KEY, kmr_pkg::DIGIT_ZERO, 8'h00);
        send_beat(kmr_pkg::ACT_KEY, 16'hFFFF, 8'hFF);
        send_beat(kmr_pkg::ACT_KEY, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_STOP, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_KEY, 16'h5AA5, 8'hA5);
        send_beat(kmr_pkg::ACT_PLAY, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_STEP, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_STEP, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_RECORD, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_KEY, 16'h0032, 8'h00);
        send_beat(kmr_pkg::ACT_KEY, 16'hA55A, 8'h5A);
        send_beat(kmr_pkg::ACT_PLAY, 16'h0000, 8'h00);
        repeat (6) send_beat(kmr_pkg::ACT_STEP, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_PLAY, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_STEP, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_RECORD, 16'h0000, 8'h00);
        send_beat(kmr_pkg::ACT_KEY, kmr_pkg::DIGIT_NINE, 8'h00);
        send_beat(kmr_pkg::ACT_KEY, 16'h002F, 8'h00);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 61 : 0;
            rx_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 34 : 0;
            if (phase == 1)
            begin
                hold_asked++;
                send_beat(kmr_pkg::ACT_RECORD, 16'h0000, 8'h00);
                send_beat(kmr_pkg::ACT_KEY, 16'h0031, 8'h00);
                repeat (kmr_pkg::STORE_DEPTH + 1)
                begin
                    send_beat(kmr_pkg::ACT_KEY, 16'($urandom_range(65535)),
                              8'($urandom_range(255)));
                end
                send_beat(kmr_pkg::ACT_PLAY, 16'h0000, 8'h00);
                repeat (30) send_beat(kmr_pkg::ACT_STEP, 16'h0000, 8'h00);
            end
            while (counted_beats < (phase + 1) * PHASE_BEATS + 25)
            begin
                run_session($urandom_range(10));
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_left != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
